// ===== sv/chte_pkg.sv =====
package chte_pkg;

    localparam int MAX_TABLES_DEF = 4;
    localparam int LOG_DEPTH_DEF  = 12;
    localparam int MAX_PROBES_DEF = 10;
    localparam int KEY_WIDTH_DEF  = 32;

    localparam int HASH_BITS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_TABLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_BUCKETS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_3      = 3'd5;

    localparam logic [63:0] MULT_0_RST = 64'd11400714819323198485;
    localparam logic [63:0] MULT_1_RST = 64'd14029467366897019727;
    localparam logic [63:0] MULT_2_RST = 64'd1609587929392839161;
    localparam logic [63:0] MULT_3_RST = 64'd9650029242287828579;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FAILED   = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

endpackage

// ===== sv/chte_if.sv =====
interface chte_in_if #(parameter int KEY_WIDTH = 32);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          value;
    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface chte_out_if #(parameter int KEY_WIDTH = 32);
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [15:0]          count;
    logic [31:0]          result_value;
    logic [KEY_WIDTH-1:0] dropped_key;
    modport source (output valid, status, count, result_value, dropped_key, input ready);
    modport sink   (input valid, status, count, result_value, dropped_key, output ready);
endinterface

// ===== sv/chte_ram.sv =====
module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/chte_front.sv =====
// accepts words into a two-entry queue that the probe engine drains
module chte_front
    import chte_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    chte_in_if.sink              in_ch,
    output logic                 q_valid,
    input  logic                 q_pop,
    output logic                 q_opcode,
    output logic [KEY_WIDTH-1:0] q_key,
    output logic [31:0]          q_value
);
    localparam int QW = 1 + KEY_WIDTH + 32;

    logic [QW-1:0] slot_reg [2];
    logic          rd_ptr_reg, rd_ptr_next;
    logic          wr_ptr_reg, wr_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          push;

    assign in_ch.ready = (fill_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (fill_reg != 2'd0);
    assign {q_opcode, q_key, q_value} = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {in_ch.opcode, in_ch.key, in_ch.value};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointers disagree on empty");
endmodule

// ===== sv/chte_back.sv =====
// probe engine: hash, read bucket, decide, write; takes no new word until the last result is taken
module chte_back
    import chte_pkg::*;
#(
    parameter int MAX_TABLES = MAX_TABLES_DEF,
    parameter int LOG_DEPTH  = LOG_DEPTH_DEF,
    parameter int MAX_PROBES = MAX_PROBES_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           num_tables,
    input  logic [3:0]           log_buckets,
    input  logic [63:0]          mult [4],
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic                 q_opcode,
    input  logic [KEY_WIDTH-1:0] q_key,
    input  logic [31:0]          q_value,
    chte_out_if.source           out_ch
);
    localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int AW    = $clog2(MAX_TABLES) + LOG_DEPTH;
    localparam int DEPTH = MAX_TABLES << LOG_DEPTH;
    localparam int PW    = $clog2(MAX_PROBES + 1);
    localparam int EW    = COUNT_WIDTH + KEY_WIDTH + 32;
    localparam int CLRW  = AW + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL, S_SHIFT, S_READ, S_DECIDE, S_OUT
    } state_t;

    state_t              state_reg;
    logic                op_reg;
    logic [KEY_WIDTH-1:0] ck_reg;
    logic [31:0]          cv_reg;
    logic [COUNT_WIDTH-1:0] cc_reg;
    logic [TW-1:0]        t_reg;
    logic [PW-1:0]        probe_reg;
    logic [AW-1:0]        addr_reg;
    logic [63:0]          pp_lo_reg, pp_mid_reg, prod_reg;
    logic [CLRW-1:0]      clr_reg;
    logic [2:0]           st_reg;
    logic [COUNT_WIDTH-1:0] ocnt_reg;
    logic [31:0]          oval_reg;
    logic [KEY_WIDTH-1:0] okey_reg;

    logic [TW:0]          nt;
    logic [3:0]           lb;
    logic [63:0]          m_sel, key64, hash;
    logic [LOG_DEPTH-1:0] bucket;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [EW-1:0]        wdata, rdata;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [KEY_WIDTH-1:0] r_key;
    logic [31:0]          r_val;
    logic [COUNT_WIDTH:0] sum;
    logic [TW:0]          t_inc;
    logic                 last_t;

    chte_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        if (num_tables == 3'd0)
            nt = (TW+1)'(1);
        else if (32'(num_tables) > MAX_TABLES)
            nt = (TW+1)'(MAX_TABLES);
        else
            nt = (TW+1)'(num_tables);
        if (log_buckets == 4'd0)
            lb = 4'd1;
        else if (32'(log_buckets) > LOG_DEPTH)
            lb = 4'(LOG_DEPTH);
        else
            lb = log_buckets;
        m_sel  = mult[2'(t_reg)];
        key64  = 64'(ck_reg);
        hash   = prod_reg >> (7'd64 - 7'(lb));
        bucket = LOG_DEPTH'(hash);
        // bucket address goes to the ram during the read state
        raddr  = AW'({t_reg, bucket});
        {r_cnt, r_key, r_val} = rdata;
        sum    = {1'b0, r_cnt} + {1'b0, cc_reg};
        t_inc  = (TW+1)'(t_reg) + (TW+1)'(1);
        last_t = (t_inc >= nt);
    end

    // memory write: clearing sweep or the decide step of an insert
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = {cc_reg, ck_reg, cv_reg};
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = AW'(clr_reg);
            wdata = '0;
        end
        else if (state_reg == S_DECIDE && op_reg == OP_INSERT)
        begin
            we = 1'b1;
            if (r_cnt != '0 && r_key == ck_reg)
            begin
                wdata = {(sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0]),
                         r_key, r_val};
            end
        end
    end

    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign out_ch.valid   = (state_reg == S_OUT);
    assign out_ch.status  = st_reg;
    assign out_ch.count   = ocnt_reg;
    assign out_ch.result_value = oval_reg;
    assign out_ch.dropped_key  = okey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            t_reg     <= '0;
            probe_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLRW'(1);
                    if (clr_reg == CLRW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    t_reg     <= '0;
                    probe_reg <= '0;
                    if (q_valid)
                        state_reg <= S_MUL;
                end
                S_MUL:   state_reg <= S_SHIFT;
                S_SHIFT: state_reg <= S_READ;
                S_READ:  state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    probe_reg <= probe_reg + PW'(1);
                    t_reg     <= last_t ? '0 : TW'(t_inc);
                    if (op_reg == OP_LOOKUP)
                    begin
                        if ((r_cnt != '0 && r_key == ck_reg) || last_t)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_MUL;
                    end
                    else if (r_cnt == '0 || r_key == ck_reg ||
                             probe_reg == PW'(MAX_PROBES - 1))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_MUL;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath: 64x64 low product from three 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            op_reg <= q_opcode;
            ck_reg <= q_key;
            cv_reg <= q_value;
            cc_reg <= COUNT_WIDTH'(1);
        end
        if (state_reg == S_MUL)
        begin
            pp_lo_reg  <= 64'(key64[31:0]) * 64'(m_sel[31:0]);
            pp_mid_reg <= 64'(32'(key64[31:0] * m_sel[63:32]))
                        + 64'(32'(key64[63:32] * m_sel[31:0]));
        end
        if (state_reg == S_SHIFT)
            prod_reg <= pp_lo_reg + {pp_mid_reg[31:0], 32'd0};
        if (state_reg == S_READ)
            addr_reg <= raddr;
        if (state_reg == S_DECIDE)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                okey_reg <= '0;
                if (r_cnt != '0 && r_key == ck_reg)
                begin
                    st_reg   <= ST_HIT;
                    ocnt_reg <= r_cnt;
                    oval_reg <= r_val;
                end
                else
                begin
                    st_reg   <= ST_MISS;
                    ocnt_reg <= '0;
                    oval_reg <= '0;
                end
            end
            else if (r_cnt == '0)
            begin
                st_reg   <= ST_INSERTED;
                ocnt_reg <= '0;
                oval_reg <= '0;
                okey_reg <= '0;
            end
            else if (r_key == ck_reg)
            begin
                st_reg   <= ST_DUP;
                ocnt_reg <= sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
                oval_reg <= '0;
                okey_reg <= '0;
            end
            else
            begin
                ck_reg   <= r_key;
                cv_reg   <= r_val;
                cc_reg   <= r_cnt;
                st_reg   <= ST_FAILED;
                ocnt_reg <= r_cnt;
                oval_reg <= r_val;
                okey_reg <= r_key;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("item taken during clearing");
    assert property (@(posedge clk) disable iff (!rst_n)
        probe_reg <= PW'(MAX_PROBES))
        else $error("probe count past limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_DUP) |-> (out_ch.count != '0))
        else $error("duplicate with zero count");
endmodule

// ===== sv/cuckoo_hash_table_engine.sv =====
// cuckoo hash table: each probe runs multiply, add, bucket read, update in that order
// lookup: one probe per subtable checked, stopping at a hit or after the last of num_tables
// insert: at most MAX_PROBES probes, one item at a time in the prober
// a two-word input queue accepts while the prober works
// after rst_n the bucket counts are cleared, one entry a cycle, all MAX_TABLES<<LOG_DEPTH entries
module cuckoo_hash_table_engine
    import chte_pkg::*;
#(
    parameter int MAX_TABLES = MAX_TABLES_DEF,
    parameter int LOG_DEPTH  = LOG_DEPTH_DEF,
    parameter int MAX_PROBES = MAX_PROBES_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    chte_in_if.sink              in_ch,
    chte_out_if.source           out_ch
);
    logic [2:0]  num_tables_reg;
    logic [3:0]  log_buckets_reg;
    logic [63:0] mult_reg [4];

    logic                 q_valid, q_pop, q_opcode;
    logic [KEY_WIDTH-1:0] q_key;
    logic [31:0]          q_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tables_reg  <= 3'd2;
            log_buckets_reg <= 4'd10;
            mult_reg[0]     <= MULT_0_RST;
            mult_reg[1]     <= MULT_1_RST;
            mult_reg[2]     <= MULT_2_RST;
            mult_reg[3]     <= MULT_3_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_TABLES:  num_tables_reg  <= cfg_wdata[2:0];
                REG_LOG_BUCKETS: log_buckets_reg <= cfg_wdata[3:0];
                REG_MULT_0:      mult_reg[0]     <= cfg_wdata;
                REG_MULT_1:      mult_reg[1]     <= cfg_wdata;
                REG_MULT_2:      mult_reg[2]     <= cfg_wdata;
                REG_MULT_3:      mult_reg[3]     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    chte_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_pop(q_pop), .q_opcode(q_opcode),
        .q_key(q_key), .q_value(q_value)
    );

    chte_back #(
        .MAX_TABLES(MAX_TABLES), .LOG_DEPTH(LOG_DEPTH),
        .MAX_PROBES(MAX_PROBES), .KEY_WIDTH(KEY_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .num_tables(num_tables_reg), .log_buckets(log_buckets_reg), .mult(mult_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_opcode(q_opcode),
        .q_key(q_key), .q_value(q_value), .out_ch(out_ch)
    );
endmodule
